### rtl/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared codes and fixed field widths of the indexed max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ihq_pkg;

  localparam int FUNC_BITS     = 2;
  localparam int ITEM_BITS     = 6;
  localparam int ITEM_COUNT    = 64;
  localparam int STATUS_BITS   = 3;
  localparam int REQ_PRIO_BITS = 32;

  typedef logic [FUNC_BITS-1:0]   func_t;
  typedef logic [ITEM_BITS-1:0]   item_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam func_t FN_INSERT  = 2'd0;
  localparam func_t FN_EXTRACT = 2'd1;
  localparam func_t FN_PEEK    = 2'd2;
  localparam func_t FN_CHANGE  = 2'd3;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EMPTY   = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_ABSENT  = 3'd3;
  localparam status_t ST_PRESENT = 3'd4;

endpackage

`default_nettype wire

### rtl/ihq_ram.sv
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ihq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/indexed_max_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Indexed binary max-heap of item identifiers with signed priorities and a
// position map from item to heap slot.
// ----------------------------------------------------------------------------
//   channel  ports                                   handshake
//   input    in_func, in_item, in_priority_req       start, accepted when !busy
//   result   out_item, out_status, out_count         out_valid, one-cycle strobe
//
// Every operation gives one result word, strobed in the cycle that busy drops;
// rejects and errors never raise busy. Sift up: S_UP reads the parent or writes
// at the root; S_UPW writes and climbs or stops. Sift down: S_DN reads the left
// child or writes at a leaf; S_DNL weighs it, reads any right child; S_DNR weighs
// that; S_DNX writes and descends or stops. Insert is a bare sift up; extract adds
// S_EX0, S_EX1 and change S_CH0, S_CH1 ahead of it, paced by the heap RAM read port,
// one slot a cycle. Reset clears the count and the present flags at once; no clearing
// pass. The receiver cannot stall; a new word may be started in the strobe cycle.
`default_nettype none

module indexed_max_heap_queue #(
  parameter int CAPACITY      = 64,
  parameter int PRIORITY_BITS = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire ihq_pkg::func_t                          in_func,
  input  wire ihq_pkg::item_t                          in_item,
  input  wire logic signed [ihq_pkg::REQ_PRIO_BITS-1:0] in_priority_req,
  output logic                                         out_valid,
  output ihq_pkg::item_t                               out_item,
  output ihq_pkg::status_t                             out_status,
  output logic [$clog2(CAPACITY+1)-1:0]                out_count
);

  import ihq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int XW = AW + 2;
  localparam int PB = PRIORITY_BITS;
  localparam int EW = ITEM_BITS + PB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UP   = 4'd1;
  localparam logic [3:0] S_UPW  = 4'd2;
  localparam logic [3:0] S_DN   = 4'd3;
  localparam logic [3:0] S_DNL  = 4'd4;
  localparam logic [3:0] S_DNR  = 4'd5;
  localparam logic [3:0] S_DNX  = 4'd6;
  localparam logic [3:0] S_EX0  = 4'd7;
  localparam logic [3:0] S_EX1  = 4'd8;
  localparam logic [3:0] S_PK   = 4'd9;
  localparam logic [3:0] S_CH0  = 4'd10;
  localparam logic [3:0] S_CH1  = 4'd11;

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         at_r, at_nxt;
  logic [EW-1:0]         cur_r, cur_nxt;
  logic [EW-1:0]         best_r, best_nxt;
  logic [AW-1:0]         bidx_r, bidx_nxt;
  logic                  best_cur_r, best_cur_nxt;
  item_t                 res_item_r, res_item_nxt;
  logic [ITEM_COUNT-1:0] here_r, here_nxt;
  logic                  out_valid_r, out_valid_nxt;
  item_t                 out_item_r, out_item_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic                  hp_we, hp_re;
  logic [AW-1:0]         hp_waddr, hp_raddr;
  logic [EW-1:0]         hp_wdata, hp_rdata;
  logic                  ps_we, ps_re;
  item_t                 ps_waddr, ps_raddr;
  logic [AW-1:0]         ps_wdata, ps_rdata;

  logic signed [PB-1:0]  req_prio;
  logic signed [PB-1:0]  rd_prio, cur_prio, best_prio;
  logic [AW-1:0]         parent;
  logic [XW-1:0]         lidx, ridx, cnt_x;
  item_t                 rd_item;

  ihq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .re(hp_re), .raddr(hp_raddr), .rdata(hp_rdata)
  );

  ihq_ram #(.DEPTH(ITEM_COUNT), .WIDTH(AW)) u_pos (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
  );

  assign req_prio  = PB'(in_priority_req);
  assign rd_prio   = $signed(hp_rdata[PB-1:0]);
  assign rd_item   = hp_rdata[EW-1:PB];
  assign cur_prio  = $signed(cur_r[PB-1:0]);
  assign best_prio = $signed(best_r[PB-1:0]);
  assign parent    = AW'((at_r - AW'(1)) >> 1);
  assign lidx      = (XW'(at_r) << 1) + XW'(1);
  assign ridx      = lidx + XW'(1);
  assign cnt_x     = XW'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    at_nxt         = at_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    bidx_nxt       = bidx_r;
    best_cur_nxt   = best_cur_r;
    res_item_nxt   = res_item_r;
    here_nxt       = here_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    hp_we          = 1'b0;
    hp_waddr       = at_r;
    hp_wdata       = cur_r;
    hp_re          = 1'b0;
    hp_raddr       = '0;
    ps_we          = 1'b0;
    ps_waddr       = cur_r[EW-1:PB];
    ps_wdata       = at_r;
    ps_re          = 1'b0;
    ps_raddr       = in_item;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_item_nxt = '0;
          out_item_nxt = '0;
          case (in_func)
            FN_INSERT: begin
              if (here_r[in_item]) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_PRESENT;
              end else if (cnt_r == CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                cur_nxt            = {in_item, req_prio};
                at_nxt             = AW'(cnt_r);
                cnt_nxt            = cnt_r + CW'(1);
                here_nxt[in_item]  = 1'b1;
                state_nxt          = S_UP;
              end
            end
            FN_EXTRACT, FN_PEEK: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                hp_re     = 1'b1;
                state_nxt = (in_func == FN_PEEK) ? S_PK : S_EX0;
              end
            end
            default: begin
              if (!here_r[in_item]) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ABSENT;
              end else begin
                ps_re     = 1'b1;
                cur_nxt   = {in_item, req_prio};
                state_nxt = S_CH0;
              end
            end
          endcase
        end
      end
      S_CH0: begin
        at_nxt    = ps_rdata;
        hp_re     = 1'b1;
        hp_raddr  = ps_rdata;
        state_nxt = S_CH1;
      end
      S_CH1: begin
        state_nxt = (cur_prio < rd_prio) ? S_DN : S_UP;
      end
      S_UP: begin
        if (at_r == '0) begin
          hp_we          = 1'b1;
          ps_we          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = res_item_r;
          state_nxt      = S_IDLE;
        end else begin
          hp_re     = 1'b1;
          hp_raddr  = parent;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (cur_prio <= rd_prio) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = res_item_r;
          state_nxt      = S_IDLE;
        end else begin
          // move the parent down into the hole and climb
          hp_wdata  = hp_rdata;
          ps_waddr  = rd_item;
          at_nxt    = parent;
          state_nxt = S_UP;
        end
      end
      S_DN: begin
        if (lidx >= cnt_x) begin
          hp_we          = 1'b1;
          ps_we          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = res_item_r;
          state_nxt      = S_IDLE;
        end else begin
          hp_re     = 1'b1;
          hp_raddr  = AW'(lidx);
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        if (rd_prio > cur_prio) begin
          best_nxt     = hp_rdata;
          bidx_nxt     = AW'(lidx);
          best_cur_nxt = 1'b0;
        end else begin
          best_nxt     = cur_r;
          best_cur_nxt = 1'b1;
        end
        if (ridx < cnt_x) begin
          hp_re     = 1'b1;
          hp_raddr  = AW'(ridx);
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNX;
        end
      end
      S_DNR: begin
        if (rd_prio > best_prio) begin
          best_nxt     = hp_rdata;
          bidx_nxt     = AW'(ridx);
          best_cur_nxt = 1'b0;
        end
        state_nxt = S_DNX;
      end
      S_DNX: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (best_cur_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = res_item_r;
          state_nxt      = S_IDLE;
        end else begin
          // lift the larger child into the hole and descend
          hp_wdata  = best_r;
          ps_waddr  = best_r[EW-1:PB];
          at_nxt    = bidx_r;
          state_nxt = S_DN;
        end
      end
      S_EX0: begin
        here_nxt[rd_item] = 1'b0;
        cnt_nxt           = cnt_r - CW'(1);
        res_item_nxt      = rd_item;
        if (cnt_r == CW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = rd_item;
          state_nxt      = S_IDLE;
        end else begin
          hp_re     = 1'b1;
          hp_raddr  = AW'(cnt_r - CW'(1));
          state_nxt = S_EX1;
        end
      end
      S_EX1: begin
        cur_nxt   = hp_rdata;
        at_nxt    = '0;
        state_nxt = S_DN;
      end
      S_PK: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_item_nxt   = rd_item;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_count_nxt = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      here_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      here_r      <= here_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_r         <= at_nxt;
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    bidx_r       <= bidx_nxt;
    best_cur_r   <= best_cur_nxt;
    res_item_r   <= res_item_nxt;
    out_item_r   <= out_item_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("held count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("word accepted but dropped");

  a_cnt_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ($countones(here_r) == int'(cnt_r)))
    else $error("present flags disagree with count");

endmodule

`default_nettype wire
